>>> hw/rtl/fsrs_pkg.sv
// shared types and constants of the frequency sweep rssi scanner
package fsrs_pkg;

    typedef logic signed [8:0] t_rssi;

    localparam t_rssi       EMPTY_RSSI   = -9'sd200;
    localparam logic [15:0] SETTLE_RESET = 16'd400;

    // input item kinds
    localparam logic [1:0] KIND_STEP = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;
    localparam logic [1:0] KIND_NOP  = 2'd3;

    // per-bin phases
    localparam logic [1:0] PH_SET  = 2'd0;
    localparam logic [1:0] PH_ARM  = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_READ = 2'd3;

    // result actions
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_STROBE = 2'd2;
    localparam logic [1:0] ACT_RSSI   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_STEP   = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;
    localparam logic [1:0] REG_SETTLE = 2'd3;

endpackage

>>> hw/rtl/fsrs_ram.sv
// generic single-port-write ram with registered read
module fsrs_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/frequency_sweep_rssi_scanner_core.sv
// top level of the frequency sweep rssi scanner: sequencer, row and snapshot stores
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   kind, bin_select, clear_ready, in_band, rssi
//   out      output     o_out_valid / i_out_ready action, freq, bin, ready, row, peak, last
//   cfg      input      apb psel/penable/pwrite   paddr[3:0], pwdata, prdata, pready
//
// step, tick and no-op items load their result directly; a snapshot read first waits
// in S_RDWAIT for the registered read of the snapshot ram.
// the step that passes the last bin starts a copy of the row ram into the snapshot
// ram, one entry a cycle through the ram read port, with the input not ready through
// S_COPY and S_DRAIN. reset and every config write start a clearing pass over both
// rams, MAX_BINS entries, with no input taken. a stalled output holds off the next item.
module frequency_sweep_rssi_scanner_core #(
    parameter int MAX_BINS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [6:0]  i_bin_select,
    input  logic        i_clear_ready,
    input  logic        i_in_band,
    input  logic signed [8:0] i_rssi_level,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action,
    output logic [31:0] o_freq_hz,
    output logic [6:0]  o_current_bin,
    output logic        o_row_ready,
    output logic signed [8:0] o_row_value,
    output logic        o_peak_valid,
    output logic [31:0] o_peak_freq,
    output logic signed [8:0] o_peak_rssi,
    output logic        o_last_valid,
    output logic [31:0] o_last_freq,
    output logic signed [8:0] o_last_rssi,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_COPY   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;

    // configuration registers
    logic [31:0] r_start, n_start;
    logic [31:0] r_step, n_step;
    logic [7:0]  r_bin_count, n_bin_count;
    logic [15:0] r_settle_ticks, n_settle_ticks;

    // control
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [7:0]    r_cp_idx, n_cp_idx;
    logic          r_cp_wen;
    logic [AW-1:0] r_cp_waddr;
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_bin, n_bin;
    logic [15:0]   r_settle, n_settle;
    logic [31:0]   r_freq, n_freq;
    logic          r_ready, n_ready;
    logic          r_best_valid, n_best_valid;
    logic [31:0]   r_best_freq, n_best_freq;
    fsrs_pkg::t_rssi r_best_rssi, n_best_rssi;
    logic          r_rec_valid, n_rec_valid;
    logic [31:0]   r_rec_freq, n_rec_freq;
    fsrs_pkg::t_rssi r_rec_rssi, n_rec_rssi;
    logic          r_rd_inrange, n_rd_inrange;
    logic          r_rd_ready, n_rd_ready;
    logic          r_out_valid, n_out_valid;

    // output payload
    logic [1:0]  r_out_action, n_out_action;
    logic [31:0] r_out_freq, n_out_freq;
    logic [6:0]  r_out_bin, n_out_bin;
    logic        r_out_rready, n_out_rready;
    fsrs_pkg::t_rssi r_out_row, n_out_row;
    logic        out_load;

    // ram ports
    logic            row_we, snap_we;
    logic [AW-1:0]   row_waddr, snap_waddr, row_raddr, snap_raddr;
    fsrs_pkg::t_rssi row_wdata, snap_wdata, row_rdata, snap_rdata;

    logic       cfg_we, accept, do_adv, wrap;
    logic [7:0] n_bins;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept = i_in_valid & o_in_ready;

    assign n_bins = (32'(r_bin_count) > 32'(MAX_BINS)) ? 8'(MAX_BINS) : r_bin_count;
    assign wrap = ({1'b0, r_bin} + 9'd1) >= {1'b0, n_bins};

    assign row_raddr  = AW'(r_cp_idx);
    assign snap_raddr = AW'(i_bin_select);

    always_comb begin
        unique case (paddr[3:2])
            fsrs_pkg::REG_START:  prdata = r_start;
            fsrs_pkg::REG_STEP:   prdata = r_step;
            fsrs_pkg::REG_COUNT:  prdata = {24'd0, r_bin_count};
            fsrs_pkg::REG_SETTLE: prdata = {16'd0, r_settle_ticks};
            default:              prdata = 32'd0;
        endcase
    end

    always_comb begin
        n_start        = r_start;
        n_step         = r_step;
        n_bin_count    = r_bin_count;
        n_settle_ticks = r_settle_ticks;
        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_cp_idx       = r_cp_idx;
        n_phase        = r_phase;
        n_bin          = r_bin;
        n_settle       = r_settle;
        n_freq         = r_freq;
        n_ready        = r_ready;
        n_best_valid   = r_best_valid;
        n_best_freq    = r_best_freq;
        n_best_rssi    = r_best_rssi;
        n_rec_valid    = r_rec_valid;
        n_rec_freq     = r_rec_freq;
        n_rec_rssi     = r_rec_rssi;
        n_rd_inrange   = r_rd_inrange;
        n_rd_ready     = r_rd_ready;
        do_adv         = 1'b0;
        out_load       = 1'b0;
        n_out_action   = fsrs_pkg::ACT_NONE;
        n_out_freq     = r_freq;
        n_out_rready   = r_ready;
        n_out_row      = '0;
        row_we         = 1'b0;
        row_waddr      = AW'(r_bin);
        row_wdata      = i_rssi_level;
        snap_we        = r_cp_wen;
        snap_waddr     = r_cp_waddr;
        snap_wdata     = row_rdata;

        unique case (r_state)
            S_CLEAR: begin
                row_we     = 1'b1;
                row_waddr  = r_clr_addr;
                row_wdata  = fsrs_pkg::EMPTY_RSSI;
                snap_we    = 1'b1;
                snap_waddr = r_clr_addr;
                snap_wdata = fsrs_pkg::EMPTY_RSSI;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_BINS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        fsrs_pkg::KIND_STEP: begin
                            out_load = 1'b1;
                            if (n_bins != 8'd0) begin
                                unique case (r_phase)
                                    fsrs_pkg::PH_SET: begin
                                        if (!i_in_band) begin
                                            do_adv = 1'b1;
                                        end else begin
                                            n_out_action = fsrs_pkg::ACT_SET;
                                            n_phase      = fsrs_pkg::PH_ARM;
                                        end
                                    end
                                    fsrs_pkg::PH_ARM: begin
                                        n_out_action = fsrs_pkg::ACT_STROBE;
                                        n_settle     = r_settle_ticks;
                                        n_phase      = fsrs_pkg::PH_WAIT;
                                    end
                                    fsrs_pkg::PH_WAIT: begin
                                        if (r_settle == 16'd0) begin
                                            n_phase = fsrs_pkg::PH_READ;
                                        end
                                    end
                                    default: begin
                                        n_out_action = fsrs_pkg::ACT_RSSI;
                                        n_rec_valid  = 1'b1;
                                        n_rec_freq   = r_freq;
                                        n_rec_rssi   = i_rssi_level;
                                        row_we       = 1'b1;
                                        // ties keep the earlier reading
                                        if (!r_best_valid || (i_rssi_level > r_best_rssi)) begin
                                            n_best_valid = 1'b1;
                                            n_best_freq  = r_freq;
                                            n_best_rssi  = i_rssi_level;
                                        end
                                        do_adv  = 1'b1;
                                        n_phase = fsrs_pkg::PH_SET;
                                    end
                                endcase
                            end
                        end
                        fsrs_pkg::KIND_TICK: begin
                            out_load = 1'b1;
                            if (r_settle != 16'd0) begin
                                n_settle = r_settle - 16'd1;
                            end
                        end
                        fsrs_pkg::KIND_READ: begin
                            n_state      = S_RDWAIT;
                            n_rd_inrange = 32'(i_bin_select) < 32'(MAX_BINS);
                            n_rd_ready   = r_ready;
                            if (i_clear_ready) begin
                                n_ready = 1'b0;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                    if (do_adv) begin
                        if (wrap) begin
                            // sweep done: copy the row into the snapshot
                            n_bin    = 8'd0;
                            n_freq   = r_start;
                            n_ready  = 1'b1;
                            n_state  = S_COPY;
                            n_cp_idx = 8'd0;
                        end else begin
                            n_bin  = r_bin + 8'd1;
                            n_freq = r_freq + r_step;
                        end
                    end
                end
            end
            S_RDWAIT: begin
                out_load     = 1'b1;
                n_out_rready = r_rd_ready;
                n_out_row    = r_rd_inrange ? snap_rdata : fsrs_pkg::EMPTY_RSSI;
                n_state      = S_IDLE;
            end
            S_COPY: begin
                n_cp_idx = r_cp_idx + 8'd1;
                if (r_cp_idx == (n_bins - 8'd1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        if (cfg_we) begin
            unique case (paddr[3:2])
                fsrs_pkg::REG_START:  n_start        = pwdata;
                fsrs_pkg::REG_STEP:   n_step         = pwdata;
                fsrs_pkg::REG_COUNT:  n_bin_count    = pwdata[7:0];
                fsrs_pkg::REG_SETTLE: n_settle_ticks = pwdata[15:0];
                default:              n_start        = r_start;
            endcase
            n_state      = S_CLEAR;
            n_clr_addr   = '0;
            n_phase      = fsrs_pkg::PH_SET;
            n_bin        = 8'd0;
            n_settle     = 16'd0;
            n_freq       = n_start;
            n_ready      = 1'b0;
            n_best_valid = 1'b0;
            n_best_freq  = 32'd0;
            n_best_rssi  = fsrs_pkg::EMPTY_RSSI;
            n_rec_valid  = 1'b0;
            n_rec_freq   = 32'd0;
            n_rec_rssi   = '0;
        end

        n_out_bin   = out_load && (r_state == S_IDLE) ? n_bin[6:0] : r_bin[6:0];
        n_out_valid = out_load | (r_out_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start        <= 32'd0;
            r_step         <= 32'd0;
            r_bin_count    <= 8'd0;
            r_settle_ticks <= fsrs_pkg::SETTLE_RESET;
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_cp_idx       <= 8'd0;
            r_cp_wen       <= 1'b0;
            r_phase        <= fsrs_pkg::PH_SET;
            r_bin          <= 8'd0;
            r_settle       <= 16'd0;
            r_freq         <= 32'd0;
            r_ready        <= 1'b0;
            r_best_valid   <= 1'b0;
            r_best_freq    <= 32'd0;
            r_best_rssi    <= fsrs_pkg::EMPTY_RSSI;
            r_rec_valid    <= 1'b0;
            r_rec_freq     <= 32'd0;
            r_rec_rssi     <= '0;
            r_rd_inrange   <= 1'b0;
            r_rd_ready     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_start        <= n_start;
            r_step         <= n_step;
            r_bin_count    <= n_bin_count;
            r_settle_ticks <= n_settle_ticks;
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_cp_idx       <= n_cp_idx;
            r_cp_wen       <= (r_state == S_COPY);
            r_phase        <= n_phase;
            r_bin          <= n_bin;
            r_settle       <= n_settle;
            r_freq         <= n_freq;
            r_ready        <= n_ready;
            r_best_valid   <= n_best_valid;
            r_best_freq    <= n_best_freq;
            r_best_rssi    <= n_best_rssi;
            r_rec_valid    <= n_rec_valid;
            r_rec_freq     <= n_rec_freq;
            r_rec_rssi     <= n_rec_rssi;
            r_rd_inrange   <= n_rd_inrange;
            r_rd_ready     <= n_rd_ready;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_waddr <= AW'(r_cp_idx);
        if (out_load) begin
            r_out_action <= n_out_action;
            r_out_freq   <= n_out_freq;
            r_out_bin    <= n_out_bin;
            r_out_rready <= n_out_rready;
            r_out_row    <= n_out_row;
        end
    end

    // peak and last fields follow the live state; it moves when a reading is stored and a config write clears it
    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out_action;
    assign o_freq_hz     = r_out_freq;
    assign o_current_bin = r_out_bin;
    assign o_row_ready   = r_out_rready;
    assign o_row_value   = r_out_row;
    assign o_peak_valid  = r_best_valid;
    assign o_peak_freq   = r_best_freq;
    assign o_peak_rssi   = r_best_rssi;
    assign o_last_valid  = r_rec_valid;
    assign o_last_freq   = r_rec_freq;
    assign o_last_rssi   = r_rec_rssi;

    fsrs_ram #(
        .WIDTH(9),
        .DEPTH(MAX_BINS)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (row_we),
        .i_waddr(row_waddr),
        .i_wdata(row_wdata),
        .i_raddr(row_raddr),
        .o_rdata(row_rdata)
    );

    fsrs_ram #(
        .WIDTH(9),
        .DEPTH(MAX_BINS)
    ) u_snap_ram (
        .i_clk  (i_clk),
        .i_we   (snap_we),
        .i_waddr(snap_waddr),
        .i_wdata(snap_wdata),
        .i_raddr(snap_raddr),
        .o_rdata(snap_rdata)
    );

    // the copy never races a reading being stored
    a_copy_no_row_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> !row_we)
        else $error("row write during snapshot copy");

    // a peak reading implies a last reading
    a_peak_has_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_valid |-> r_rec_valid)
        else $error("peak valid without last reading");

    // the bin index stays inside the active sweep
    a_bin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (n_bins != 8'd0)) |-> (r_bin < n_bins))
        else $error("bin index beyond bin count");

    // a snapshot read loads its result on the following cycle
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == fsrs_pkg::KIND_READ) && !cfg_we) |=> r_out_valid == 1'b0 && out_load)
        else $error("snapshot read result not loaded");

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench of the frequency sweep rssi scanner core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SWEEP_BINS  = 128;
    localparam int IDLE_PCT    = 13;
    localparam int QUIET_GAP   = 300;    // covers the snapshot copy and the clearing pass
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]      kind;
        logic [6:0]      sel;
        logic            clr;
        logic            band;
        fsrs_pkg::t_rssi rssi;
    } t_sweep_item;

    typedef struct {
        logic [1:0]      action;
        logic [31:0]     freq;
        logic [6:0]      bin;
        logic            row_ready;
        fsrs_pkg::t_rssi row_value;
        logic            peak_valid;
        logic [31:0]     peak_freq;
        fsrs_pkg::t_rssi peak_rssi;
        logic            last_valid;
        logic [31:0]     last_freq;
        fsrs_pkg::t_rssi last_rssi;
    } t_sweep_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [6:0]  i_bin_select;
    logic        i_clear_ready;
    logic        i_in_band;
    logic signed [8:0] i_rssi_level;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_action;
    logic [31:0] o_freq_hz;
    logic [6:0]  o_current_bin;
    logic        o_row_ready;
    logic signed [8:0] o_row_value;
    logic        o_peak_valid;
    logic [31:0] o_peak_freq;
    logic signed [8:0] o_peak_rssi;
    logic        o_last_valid;
    logic [31:0] o_last_freq;
    logic signed [8:0] o_last_rssi;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frequency_sweep_rssi_scanner_core #(.MAX_BINS(SWEEP_BINS)) dut (.*);

    // scanner shadow state
    logic [31:0]     cfg_start, cfg_step;
    logic [7:0]      cfg_count;
    logic [15:0]     cfg_settle;
    logic [1:0]      ph;
    logic [6:0]      bin_idx;
    logic [15:0]     settle_cnt;
    fsrs_pkg::t_rssi row_mem [SWEEP_BINS];
    fsrs_pkg::t_rssi snap_mem [SWEEP_BINS];
    logic            snap_rdy, pk_valid, lst_valid;
    logic [31:0]     pk_freq, lst_freq;
    fsrs_pkg::t_rssi pk_rssi, lst_rssi;

    t_sweep_item   pending_items[$];
    t_sweep_result expected_results[$];

    int  err_count = 0;
    int  cycle_count = 0;
    logic in_taken;
    logic no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    task automatic restart_scan();
        ph = fsrs_pkg::PH_SET;
        bin_idx = '0;
        settle_cnt = '0;
        snap_rdy = 1'b0;
        pk_valid = 1'b0;
        pk_freq = '0;
        pk_rssi = fsrs_pkg::EMPTY_RSSI;
        lst_valid = 1'b0;
        lst_freq = '0;
        lst_rssi = '0;
        for (int k = 0; k < SWEEP_BINS; k++) begin
            row_mem[k] = fsrs_pkg::EMPTY_RSSI;
            snap_mem[k] = fsrs_pkg::EMPTY_RSSI;
        end
    endtask

    task automatic advance_bin(input int n);
        if (int'(bin_idx) + 1 >= n) begin
            bin_idx = '0;
            for (int k = 0; k < n; k++) snap_mem[k] = row_mem[k];
            snap_rdy = 1'b1;
        end else begin
            bin_idx = bin_idx + 7'd1;
        end
    endtask

    task automatic scan_predict(input t_sweep_item it, output t_sweep_result r);
        logic [31:0]     f;
        int              n;
        logic            ready_before;
        logic [1:0]      act;
        fsrs_pkg::t_rssi row_val;
        n = (int'(cfg_count) > SWEEP_BINS) ? SWEEP_BINS : int'(cfg_count);
        f = cfg_start + cfg_step * {25'd0, bin_idx};
        act = fsrs_pkg::ACT_NONE;
        row_val = '0;
        ready_before = snap_rdy;
        case (it.kind)
            fsrs_pkg::KIND_STEP: begin
                if (n != 0) begin
                    case (ph)
                        fsrs_pkg::PH_SET: begin
                            if (!it.band) begin
                                advance_bin(n);
                            end else begin
                                act = fsrs_pkg::ACT_SET;
                                ph = fsrs_pkg::PH_ARM;
                            end
                        end
                        fsrs_pkg::PH_ARM: begin
                            act = fsrs_pkg::ACT_STROBE;
                            settle_cnt = cfg_settle;
                            ph = fsrs_pkg::PH_WAIT;
                        end
                        fsrs_pkg::PH_WAIT: begin
                            if (settle_cnt == 0) ph = fsrs_pkg::PH_READ;
                        end
                        default: begin
                            act = fsrs_pkg::ACT_RSSI;
                            lst_freq = f;
                            lst_rssi = it.rssi;
                            lst_valid = 1'b1;
                            row_mem[bin_idx] = it.rssi;
                            // ties keep the earlier peak
                            if (!pk_valid || it.rssi > pk_rssi) begin
                                pk_valid = 1'b1;
                                pk_freq = f;
                                pk_rssi = it.rssi;
                            end
                            advance_bin(n);
                            ph = fsrs_pkg::PH_SET;
                        end
                    endcase
                end
            end
            fsrs_pkg::KIND_TICK: begin
                if (settle_cnt != 0) settle_cnt = settle_cnt - 16'd1;
            end
            fsrs_pkg::KIND_READ: begin
                row_val = snap_mem[it.sel];
                if (it.clr) snap_rdy = 1'b0;
            end
            default: ;
        endcase
        r.action = act;
        r.freq = f;
        r.bin = bin_idx;
        r.row_ready = ready_before;
        r.row_value = row_val;
        r.peak_valid = pk_valid;
        r.peak_freq = pk_freq;
        r.peak_rssi = pk_rssi;
        r.last_valid = lst_valid;
        r.last_freq = lst_freq;
        r.last_rssi = lst_rssi;
    endtask

    // driver: a new item only once the previous one has been transferred
    always @(negedge i_clk) begin
        t_sweep_item it;
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (pending_items.size() > 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    it = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_kind <= it.kind;
                    i_bin_select <= it.sel;
                    i_clear_ready <= it.clr;
                    i_in_band <= it.band;
                    i_rssi_level <= it.rssi;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_sweep_item   it;
        t_sweep_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL frequency_sweep_rssi_scanner_core");
            $finish;
        end else if (i_rst_n) begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                it.kind = i_kind;
                it.sel = i_bin_select;
                it.clr = i_clear_ready;
                it.band = i_in_band;
                it.rssi = i_rssi_level;
                scan_predict(it, want);
                expected_results.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected, action", o_action, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_action !== want.action)
                        report_mismatch("action", o_action, want.action);
                    if (o_freq_hz !== want.freq)
                        report_mismatch("freq_hz", o_freq_hz, want.freq);
                    if (o_current_bin !== want.bin)
                        report_mismatch("current_bin", o_current_bin, want.bin);
                    if (o_row_ready !== want.row_ready)
                        report_mismatch("row_ready", o_row_ready, want.row_ready);
                    if (o_row_value !== want.row_value)
                        report_mismatch("row_value", o_row_value, want.row_value);
                    if (o_peak_valid !== want.peak_valid)
                        report_mismatch("peak_valid", o_peak_valid, want.peak_valid);
                    if (o_peak_freq !== want.peak_freq)
                        report_mismatch("peak_freq", o_peak_freq, want.peak_freq);
                    if (o_peak_rssi !== want.peak_rssi)
                        report_mismatch("peak_rssi", o_peak_rssi, want.peak_rssi);
                    if (o_last_valid !== want.last_valid)
                        report_mismatch("last_valid", o_last_valid, want.last_valid);
                    if (o_last_freq !== want.last_freq)
                        report_mismatch("last_freq", o_last_freq, want.last_freq);
                    if (o_last_rssi !== want.last_rssi)
                        report_mismatch("last_rssi", o_last_rssi, want.last_rssi);
                end
            end
        end
    end

    task automatic push_item(input logic [1:0] kind, input logic [6:0] sel, input logic clr,
                             input logic band, input fsrs_pkg::t_rssi rssi);
        t_sweep_item it;
        it.kind = kind;
        it.sel = sel;
        it.clr = clr;
        it.band = band;
        it.rssi = rssi;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            fsrs_pkg::REG_START:  cfg_start = value;
            fsrs_pkg::REG_STEP:   cfg_step = value;
            fsrs_pkg::REG_COUNT:  cfg_count = value[7:0];
            default:              cfg_settle = value[15:0];
        endcase
        restart_scan();
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        repeat (QUIET_GAP) @(posedge i_clk);
    endtask

    task automatic setup_sweep(input logic [31:0] start, input logic [31:0] step,
                               input logic [7:0] count, input logic [15:0] settle);
        wait_drained();
        repeat (QUIET_GAP) @(posedge i_clk);
        cfg_write(fsrs_pkg::REG_START, start);
        cfg_write(fsrs_pkg::REG_STEP, step);
        cfg_write(fsrs_pkg::REG_COUNT, {24'd0, count});
        cfg_write(fsrs_pkg::REG_SETTLE, {16'd0, settle});
    endtask

    // mostly complete bin sequences with random content, plus reads and noise
    task automatic gen_sweep_items(input int target, input int settle);
        int made;
        int pick;
        int ticks;
        logic band;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                push_item(fsrs_pkg::KIND_READ, 7'($urandom), 1'($urandom), 1'($urandom),
                          9'($urandom));
                made++;
            end else if (pick < 11) begin
                push_item(fsrs_pkg::KIND_NOP, 7'($urandom), 1'($urandom), 1'($urandom),
                          9'($urandom));
                made++;
            end else if (pick < 14) begin
                push_item(2'($urandom), 7'($urandom), 1'($urandom), 1'($urandom),
                          9'($urandom));
                made++;
            end else begin
                band = ($urandom_range(0, 9) != 0);
                push_item(fsrs_pkg::KIND_STEP, 7'($urandom), 1'($urandom), band, 9'($urandom));
                made++;
                if (band) begin
                    push_item(fsrs_pkg::KIND_STEP, 7'($urandom), 1'($urandom), 1'($urandom),
                              9'($urandom));
                    ticks = (settle > 8) ? 8 : settle;
                    if ($urandom_range(0, 3) == 0) ticks += $urandom_range(0, 2);
                    // an early wait step stays in the wait phase while the settle count is not zero
                    if ($urandom_range(0, 4) == 0) begin
                        push_item(fsrs_pkg::KIND_STEP, 7'($urandom), 1'($urandom),
                                  1'($urandom), 9'($urandom));
                        made++;
                    end
                    for (int t = 0; t < ticks; t++)
                        push_item(fsrs_pkg::KIND_TICK, 7'($urandom), 1'($urandom),
                                  1'($urandom), 9'($urandom));
                    push_item(fsrs_pkg::KIND_STEP, 7'($urandom), 1'($urandom), 1'($urandom),
                              9'($urandom));
                    push_item(fsrs_pkg::KIND_STEP, 7'($urandom), 1'($urandom), 1'($urandom),
                              9'($urandom));
                    made += ticks + 3;
                end
            end
        end
    endtask

    initial begin
        logic [15:0] rnd_settle;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = fsrs_pkg::KIND_NOP;
        i_bin_select = '0;
        i_clear_ready = 1'b0;
        i_in_band = 1'b0;
        i_rssi_level = '0;
        i_out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_taken = 1'b0;
        no_idle = 1'b0;
        cfg_start = '0;
        cfg_step = '0;
        cfg_count = '0;
        cfg_settle = fsrs_pkg::SETTLE_RESET;
        restart_scan();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: no bins, steps do nothing
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, 9'sd0);
        push_item(fsrs_pkg::KIND_TICK, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_READ, 7'd0, 1'b1, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_READ, 7'd127, 1'b0, 1'b1, -9'sd1);
        push_item(fsrs_pkg::KIND_NOP, 7'd127, 1'b1, 1'b1, 9'sd255);

        // two bins with wrapping frequencies, out of band skip, ties on the peak
        setup_sweep(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd2, 16'd1);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_TICK, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_TICK, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b0, 9'sd255);
        push_item(fsrs_pkg::KIND_READ, 7'd1, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_READ, 7'd0, 1'b1, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_READ, 7'd1, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, 9'sd0);
        push_item(fsrs_pkg::KIND_TICK, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, -9'sd256);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_READ, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_READ, 7'd2, 1'b1, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, 9'sd0);
        push_item(fsrs_pkg::KIND_TICK, 7'd0, 1'b0, 1'b0, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, 9'sd0);
        push_item(fsrs_pkg::KIND_STEP, 7'd0, 1'b0, 1'b1, 9'sd255);

        setup_sweep($urandom, $urandom, 8'd0, 16'd0);
        gen_sweep_items(20, 0);

        setup_sweep(32'd0, 32'd0, 8'd3, 16'hFFFF);
        gen_sweep_items(60, 65535);

        setup_sweep(32'd1000, 32'd25000, 8'd4, 16'd0);
        gen_sweep_items(220, 0);

        setup_sweep(32'hFFFF_FF00, 32'h40, 8'd1, 16'd2);
        gen_sweep_items(180, 2);

        setup_sweep($urandom, 32'hFFFF_FFFF, 8'd128, 16'd0);
        gen_sweep_items(700, 0);

        rnd_settle = 16'($urandom_range(0, 4));
        setup_sweep($urandom, $urandom, 8'($urandom_range(1, 8)), rnd_settle);
        no_idle = 1'b1;
        gen_sweep_items(330, int'(rnd_settle));
        wait_drained();
        no_idle = 1'b0;

        rnd_settle = 16'($urandom_range(1, 3));
        setup_sweep($urandom, $urandom, 8'($urandom_range(2, 16)), rnd_settle);
        gen_sweep_items(150, int'(rnd_settle));
        // sender holds off until every result is back
        wait_drained();
        gen_sweep_items(150, int'(rnd_settle));

        wait_drained();
        repeat (QUIET_GAP) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS frequency_sweep_rssi_scanner_core");
        end else begin
            $display("FAIL frequency_sweep_rssi_scanner_core");
        end
        $finish;
    end

endmodule
